// ----- src/aob_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aob_pkg - shared types and constants of the additive oscillator bank
// Opcodes, the load-word struct and the fixed constants of the sample path.
// ----------------------------------------------------------------------------
package aob_pkg;

    // default sizes, handed down from the top level
    localparam int NUM_OSC_DEF      = 79;
    localparam int WAVE_ENTRIES_DEF = 4096;

    // fixed field widths of the input word
    localparam int SLOT_W  = 12;
    localparam int VALUE_W = 32;
    localparam int AMP_W   = 16;
    localparam int WAVE_DW = 16;
    localparam int ACC_W   = 32;
    localparam int DAC_W   = 16;

    // midpoint in Q8 and the sample given while no note is held
    localparam logic [ACC_W-1:0] MIDPOINT_Q8 = 32'h007F_FF00;
    localparam logic [DAC_W-1:0] IDLE_SAMPLE = 16'h7FFF;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_STEP = 2'd1,
        OP_AMP  = 2'd2,
        OP_WAVE = 2'd3
    } aob_op_t;

    // one load word towards the oscillator store
    typedef struct packed {
        logic               step_we;
        logic               amp_we;
        logic [SLOT_W-1:0]  slot;
        logic [VALUE_W-1:0] value;
    } aob_load_t;

endpackage

// ----- src/aob_osc_state.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aob_osc_state - per-oscillator phase, step and amplitude store
// Three small memories with registered reads; phase and amplitude carry valid
// bits so that an entry never written reads as zero after reset.
// ----------------------------------------------------------------------------
module aob_osc_state
    import aob_pkg::*;
#(
    parameter int NUM_OSC = NUM_OSC_DEF,
    parameter int OSC_W   = (NUM_OSC > 1) ? $clog2(NUM_OSC) : 1
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  aob_load_t           ld,
    input  logic                rd_en,
    input  logic [OSC_W-1:0]    rd_idx,
    input  logic                ph_we,
    input  logic [OSC_W-1:0]    ph_idx,
    input  logic [VALUE_W-1:0]  ph_data,
    output logic [VALUE_W-1:0]  rd_phase,
    output logic [VALUE_W-1:0]  rd_step,
    output logic [AMP_W-1:0]    rd_amp
);

    logic [VALUE_W-1:0] phase_mem [NUM_OSC];
    logic [VALUE_W-1:0] step_mem  [NUM_OSC];
    logic [AMP_W-1:0]   amp_mem   [NUM_OSC];

    logic [NUM_OSC-1:0] phase_vld_reg;
    logic [NUM_OSC-1:0] amp_vld_reg;

    logic [VALUE_W-1:0] phase_rd_reg;
    logic [VALUE_W-1:0] step_rd_reg;
    logic [AMP_W-1:0]   amp_rd_reg;
    logic               phase_rv_reg;
    logic               amp_rv_reg;

    logic [OSC_W-1:0]   ld_idx;

    assign ld_idx = ld.slot[OSC_W-1:0];

    // write ports and registered reads of the three stores
    always_ff @(posedge clk)
    begin
        if (ph_we)
        begin
            phase_mem[ph_idx] <= ph_data;
        end
        if (ld.step_we)
        begin
            step_mem[ld_idx] <= ld.value;
        end
        if (ld.amp_we)
        begin
            amp_mem[ld_idx] <= ld.value[AMP_W-1:0];
        end
        if (rd_en)
        begin
            phase_rd_reg <= phase_mem[rd_idx];
            step_rd_reg  <= step_mem[rd_idx];
            amp_rd_reg   <= amp_mem[rd_idx];
        end
    end

    // mark written entries; reset clears all marks at once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_vld_reg <= '0;
            amp_vld_reg   <= '0;
            phase_rv_reg  <= 1'b0;
            amp_rv_reg    <= 1'b0;
        end
        else
        begin
            if (ph_we)
            begin
                phase_vld_reg[ph_idx] <= 1'b1;
            end
            if (ld.amp_we)
            begin
                amp_vld_reg[ld_idx] <= 1'b1;
            end
            if (rd_en)
            begin
                phase_rv_reg <= phase_vld_reg[rd_idx];
                amp_rv_reg   <= amp_vld_reg[rd_idx];
            end
        end
    end

    // an entry never written reads as zero
    assign rd_phase = phase_rv_reg ? phase_rd_reg : '0;
    assign rd_amp   = amp_rv_reg ? amp_rd_reg : '0;
    assign rd_step  = step_rd_reg;

endmodule

// ----- src/aob_wave_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aob_wave_mem - shared wave table
// Single write port from load words, one registered read port for the walk.
// ----------------------------------------------------------------------------
module aob_wave_mem
    import aob_pkg::*;
#(
    parameter int WAVE_ENTRIES = WAVE_ENTRIES_DEF,
    parameter int WAVE_W       = $clog2(WAVE_ENTRIES)
)
(
    input  logic               clk,
    input  logic               we,
    input  logic [WAVE_W-1:0]  waddr,
    input  logic [WAVE_DW-1:0] wdata,
    input  logic               re,
    input  logic [WAVE_W-1:0]  raddr,
    output logic [WAVE_DW-1:0] rdata
);

    logic [WAVE_DW-1:0] wave_mem [WAVE_ENTRIES];
    logic [WAVE_DW-1:0] rdata_reg;

    // write a load word, read one entry per walk step
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            wave_mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= wave_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/aob_mac.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aob_mac - shared multiply-accumulate unit
// One signed 16x16 product per cycle, registered, then a wrapping 32-bit sum.
// ----------------------------------------------------------------------------
module aob_mac
    import aob_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               clear,
    input  logic               in_valid,
    input  logic [WAVE_DW-1:0] wave,
    input  logic [AMP_W-1:0]   amp,
    output logic [ACC_W-1:0]   acc,
    output logic               busy
);

    logic [ACC_W-1:0] prod_reg;
    logic             prod_vld_reg;
    logic [ACC_W-1:0] acc_reg;
    logic signed [WAVE_DW-1:0] wave_s;
    logic signed [AMP_W-1:0]   amp_s;
    logic signed [ACC_W-1:0]   mult;
    logic signed [ACC_W-1:0] prod;

    // both operands count as signed halfwords
    assign wave_s = wave;
    assign amp_s  = amp;
    assign mult   = ACC_W'(wave_s) * ACC_W'(amp_s);

    // a silent oscillator adds nothing, whatever its wave entry holds
    assign prod = (amp != '0) ? mult : '0;

    // register the product
    always_ff @(posedge clk)
    begin
        prod_reg <= prod;
    end

    // accumulate with 32-bit wrap
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
            acc_reg      <= '0;
        end
        else
        begin
            prod_vld_reg <= in_valid;
            if (clear)
            begin
                acc_reg <= '0;
            end
            else if (prod_vld_reg)
            begin
                acc_reg <= acc_reg + prod_reg;
            end
        end
    end

    assign acc  = acc_reg;
    assign busy = prod_vld_reg;

endmodule

// ----- src/additive_oscillator_bank.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// additive_oscillator_bank - bank of phase-accumulator oscillators
// Load words set steps, amplitudes and wave entries; each tick emits a DAC sample,
// and with notes held walks every oscillator through one shared multiply-accumulate.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: tuser carries the opcode (tick, write step, write amplitude,
//   write wave entry); tdata carries slot, value and notes_active.
//   Master stream: one 16-bit DAC sample for each tick word, none for loads.
//   Load words are taken back to back while no tick is in work.
//   A tick with notes held walks every oscillator through the read / add /
//   multiply / accumulate pipeline, one oscillator entering per cycle, and
//   the walk is bound by the single multiplier and the one read port of each
//   store. A tick without notes gives 0x7FFF as soon as the output register
//   is free.
//   tready stays low while a tick is in work, so the bank takes no new word
//   until the sample of that tick sits in the output register.
//   Reset clears all phases and amplitudes through valid bits at once; steps
//   and wave entries are undefined until written.
//   If the receiver stalls, the sample waits in the output register and load
//   words are still taken; a further tick completes its walk, then holds
//   until the earlier sample has gone.
// ----------------------------------------------------------------------------
module additive_oscillator_bank
    import aob_pkg::*;
#(
    parameter int NUM_OSC      = NUM_OSC_DEF,
    parameter int WAVE_ENTRIES = WAVE_ENTRIES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // slot[11:0], value[43:12], notes_active[44]
    input  logic [1:0]  s_axis_tuser,   // opcode[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // audio_out[15:0]
);

    localparam int OSC_W  = (NUM_OSC > 1) ? $clog2(NUM_OSC) : 1;
    localparam int WAVE_W = $clog2(WAVE_ENTRIES);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [OSC_W-1:0]   k_reg;
    logic [OSC_W-1:0]   k_next;
    logic               s1_vld_reg;
    logic [OSC_W-1:0]   s1_idx_reg;
    logic               s2_vld_reg;
    logic [AMP_W-1:0]   amp2_reg;
    logic               silent_reg;
    logic               silent_next;
    logic               m_vld_reg;
    logic               m_vld_next;
    logic [DAC_W-1:0]   m_data_reg;
    logic [DAC_W-1:0]   m_data_next;

    logic               accept;
    aob_op_t            op;
    logic [SLOT_W-1:0]  slot;
    logic [VALUE_W-1:0] value;
    logic               notes_active;
    logic               slot_ok;
    aob_load_t          ld;

    logic [VALUE_W-1:0] rd_phase;
    logic [VALUE_W-1:0] rd_step;
    logic [AMP_W-1:0]   rd_amp;
    logic [VALUE_W-1:0] phase_sum;
    logic [WAVE_DW-1:0] wave_rd;
    logic [ACC_W-1:0]   acc;
    logic               mac_busy;
    logic [ACC_W-1:0]   acc_mid;
    logic               out_free;

    // unpack the input word
    assign op           = aob_op_t'(s_axis_tuser);
    assign slot         = s_axis_tdata[11:0];
    assign value        = s_axis_tdata[43:12];
    assign notes_active = s_axis_tdata[44];
    assign accept       = s_axis_tvalid && s_axis_tready;
    assign slot_ok      = slot < SLOT_W'(NUM_OSC);

    // load words towards the oscillator store
    always_comb
    begin
        ld.step_we = accept && (op == OP_STEP) && slot_ok;
        ld.amp_we  = accept && (op == OP_AMP) && slot_ok;
        ld.slot    = slot;
        ld.value   = value;
    end

    aob_osc_state #(
        .NUM_OSC (NUM_OSC),
        .OSC_W   (OSC_W)
    ) u_osc_state (
        .clk      (clk),
        .rst_n    (rst_n),
        .ld       (ld),
        .rd_en    (state_reg == ST_RUN),
        .rd_idx   (k_reg),
        .ph_we    (s1_vld_reg),
        .ph_idx   (s1_idx_reg),
        .ph_data  (phase_sum),
        .rd_phase (rd_phase),
        .rd_step  (rd_step),
        .rd_amp   (rd_amp)
    );

    // advance the phase of the oscillator just read
    assign phase_sum = rd_phase + rd_step;

    aob_wave_mem #(
        .WAVE_ENTRIES (WAVE_ENTRIES),
        .WAVE_W       (WAVE_W)
    ) u_wave_mem (
        .clk   (clk),
        .we    (accept && (op == OP_WAVE)),
        .waddr (slot[WAVE_W-1:0]),
        .wdata (value[WAVE_DW-1:0]),
        .re    (s1_vld_reg),
        .raddr (phase_sum[16 +: WAVE_W]),
        .rdata (wave_rd)
    );

    aob_mac u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .clear    (accept && (op == OP_TICK)),
        .in_valid (s2_vld_reg),
        .wave     (wave_rd),
        .amp      (amp2_reg),
        .acc      (acc),
        .busy     (mac_busy)
    );

    // hold the amplitude alongside the wave read
    always_ff @(posedge clk)
    begin
        amp2_reg   <= rd_amp;
        s1_idx_reg <= k_reg;
    end

    assign acc_mid  = acc + MIDPOINT_Q8;
    assign out_free = !m_vld_reg || m_axis_tready;

    // sequencer: next state and output register
    always_comb
    begin
        state_next  = state_reg;
        k_next      = k_reg;
        silent_next = silent_reg;
        m_vld_next  = m_vld_reg && !m_axis_tready;
        m_data_next = m_data_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (op == OP_TICK))
                begin
                    k_next      = '0;
                    silent_next = !notes_active;
                    state_next  = notes_active ? ST_RUN : ST_FINISH;
                end
            end
            ST_RUN:
            begin
                if (k_reg == OSC_W'(NUM_OSC - 1))
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    k_next = k_reg + OSC_W'(1);
                end
            end
            ST_DRAIN:
            begin
                if (!s1_vld_reg && !s2_vld_reg && !mac_busy)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    m_vld_next  = 1'b1;
                    m_data_next = silent_reg ? IDLE_SAMPLE : acc_mid[23:8];
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // hold state, walk counter, pipeline marks and the output word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            k_reg      <= '0;
            silent_reg <= 1'b0;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            m_vld_reg  <= 1'b0;
            m_data_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            k_reg      <= k_next;
            silent_reg <= silent_next;
            s1_vld_reg <= (state_reg == ST_RUN);
            s2_vld_reg <= s1_vld_reg;
            m_vld_reg  <= m_vld_next;
            m_data_reg <= m_data_next;
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_vld_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

// ----- src/aob_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aob_checker - port-level checks of the oscillator bank
// Watches both stream channels and is bound to every top-level instance.
// ----------------------------------------------------------------------------
module aob_checker
    import aob_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    // a stalled sample stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("sample dropped while stalled");

    // a stalled sample keeps its value
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("sample changed while stalled");

    // a tick word makes the block busy in the next cycle
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_TICK) |=> !s_axis_tready)
        else $error("tick word did not start a walk");

    // a load word never produces a sample
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser != OP_TICK)
        |=> !$rose(m_axis_tvalid))
        else $error("sample after a load word");

    // a new sample appears only at the end of a tick in work
    a_sample_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("sample without a tick in work");

endmodule

bind additive_oscillator_bank aob_checker u_aob_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- test/additive_oscillator_bank_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// additive_oscillator_bank_test - self-checking bench for the oscillator bank
// Streams load and tick words into the bank under changing back-pressure and
// compares every DAC sample with a cycle-free model of the oscillator walk.
// ----------------------------------------------------------------------------
module additive_oscillator_bank_test;
    import aob_pkg::*;

    localparam int NOSC         = NUM_OSC_DEF;
    localparam int NWAVE        = WAVE_ENTRIES_DEF;
    localparam int STALL_LIMIT  = 4000;
    localparam int NOSC_SETTLE  = NUM_OSC_DEF;
    localparam int SETTLE_TIME  = 2 * NOSC_SETTLE + 10;
    localparam int RANDOM_WORDS = 150;
    localparam int FLOOD_OSC    = 9;

    // ------------------------------------------------------------------------
    // Oscillator bank predictor and sample scoreboard
    // ------------------------------------------------------------------------
    class osc_bank_scoreboard;
        logic [31:0] phase_acc  [NOSC];
        logic [31:0] phase_step [NOSC];
        logic [15:0] gain       [NOSC];
        logic [15:0] wave       [NWAVE];
        bit          wave_known [NWAVE];
        logic [15:0] sample_q   [$];
        int          mismatches;
        int          samples_checked;
        int          active_ticks;

        function new();
            for (int k = 0; k < NOSC; k++)
            begin
                phase_acc[k]  = '0;
                phase_step[k] = '0;
                gain[k]       = '0;
            end
            for (int i = 0; i < NWAVE; i++)
            begin
                wave[i]       = '0;
                wave_known[i] = 1'b0;
            end
            mismatches      = 0;
            samples_checked = 0;
            active_ticks    = 0;
        endfunction

        // wave entry that oscillator k reads on the next tick with notes held
        function logic [11:0] read_index(int k);
            logic [31:0] p;
            p = phase_acc[k] + phase_step[k];
            return p[27:16];
        endfunction

        // first entry a sounding oscillator would read before it was loaded
        function int unloaded_entry();
            logic [11:0] idx;
            for (int k = 0; k < NOSC; k++)
            begin
                idx = read_index(k);
                if (gain[k] != '0 && !wave_known[idx])
                    return int'(idx);
            end
            return -1;
        endfunction

        // advance every phase and mix the sounding oscillators
        function logic [15:0] mix_tick();
            logic        [31:0] sum;
            logic signed [31:0] prod;
            logic signed [15:0] w;
            logic signed [15:0] a;
            sum = '0;
            for (int k = 0; k < NOSC; k++)
            begin
                phase_acc[k] = phase_acc[k] + phase_step[k];
                if (gain[k] != '0)
                begin
                    w    = wave[phase_acc[k][27:16]];
                    a    = gain[k];
                    prod = w * a;
                    sum  = sum + prod;
                end
            end
            sum = sum + MIDPOINT_Q8;
            return sum[23:8];
        endfunction

        function void note_word(aob_op_t op, logic [11:0] slot, logic [31:0] value,
                                logic notes);
            case (op)
                OP_TICK:
                begin
                    if (notes)
                    begin
                        sample_q.push_back(mix_tick());
                        active_ticks++;
                    end
                    else
                        sample_q.push_back(IDLE_SAMPLE);
                end
                OP_STEP:
                    if (slot < NOSC)
                        phase_step[slot] = value;
                OP_AMP:
                    if (slot < NOSC)
                        gain[slot] = value[15:0];
                default:
                begin
                    wave[slot]       = value[15:0];
                    wave_known[slot] = 1'b1;
                end
            endcase
        endfunction

        function void check_sample(logic [15:0] got);
            logic [15:0] want;
            if (sample_q.size() == 0)
            begin
                if (mismatches < 10)
                    $display("[%0t] unexpected sample %h with nothing pending", $realtime, got);
                mismatches++;
            end
            else
            begin
                want = sample_q.pop_front();
                if (got !== want)
                begin
                    if (mismatches < 10)
                        $display("[%0t] audio_out mismatch on sample %0d: expected %h, got %h",
                                 $realtime, samples_checked, want, got);
                    mismatches++;
                end
                samples_checked++;
            end
        endfunction

        function int pending();
            return sample_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and block under test
    // ------------------------------------------------------------------------
    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata  = '0;   // slot[11:0], value[43:12], notes_active[44]
    logic [1:0]  s_axis_tuser  = '0;   // opcode[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;         // audio_out[15:0]

    osc_bank_scoreboard sb;

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int rx_hold_len  = 0;
    int rx_hold_id   = 0;
    int rx_hold_seen = 0;
    int rx_hold_left = 0;
    int idle_cycles  = 0;
    int words_taken  = 0;
    int fill_words   = 0;

    additive_oscillator_bank u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // free-running clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // receiver: random stalls, or a long hold-off when one is requested
    always @(posedge clk)
    begin
        if (rx_hold_id != rx_hold_seen)
        begin
            rx_hold_seen = rx_hold_id;
            rx_hold_left = rx_hold_len;
        end
        if (rx_hold_left > 0)
        begin
            rx_hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // check every sample word taken from the bank
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_sample(m_axis_tdata);
    end

    // watchdog: end the run if neither side moves a word for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("[%0t] timeout: no word moved for %0d cycles", $realtime, idle_cycles);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus tasks
    // ------------------------------------------------------------------------

    // offer one word, after an optional idle gap, and hold it until taken
    task automatic send_word(aob_op_t op, logic [11:0] slot, logic [31:0] value,
                             logic notes);
        if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < tx_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {3'b000, notes, value, slot};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_word(op, slot, value, notes);
        words_taken++;
    endtask

    // load any wave entry the next tick would read unwritten, then tick
    task automatic play_tick(logic notes);
        int idx;
        if (notes)
        begin
            idx = sb.unloaded_entry();
            while (idx >= 0)
            begin
                send_word(OP_WAVE, idx[11:0], $urandom, 1'($urandom_range(1)));
                fill_words++;
                idx = sb.unloaded_entry();
            end
        end
        send_word(OP_TICK, 12'($urandom_range(4095)), $urandom, notes);
    endtask

    // give the first oscillators the same gain and the same wave sample, then tick
    task automatic flood_tick(logic [15:0] level, logic [15:0] sample);
        for (int k = 0; k < FLOOD_OSC; k++)
            send_word(OP_AMP, 12'(k), {16'($urandom_range(16'hFFFF)), level}, 1'b0);
        for (int k = 0; k < FLOOD_OSC; k++)
            send_word(OP_WAVE, sb.read_index(k), {16'h0000, sample}, 1'b1);
        play_tick(1'b1);
    endtask

    // lower valid and wait until every sample has come back
    task automatic drain_samples();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    function automatic logic [31:0] pick_step();
        int r;
        r = $urandom_range(99);
        if (r < 5)
            return 32'h0000_0000;
        else if (r < 10)
            return 32'hFFFF_FFFF;
        else if (r < 55)
            return $urandom_range(32'h00FF_FFFF);
        return $urandom;
    endfunction

    function automatic logic [15:0] pick_gain();
        int r;
        r = $urandom_range(99);
        if (r < 25)
            return 16'h0000;
        else if (r < 30)
            return 16'h8000;
        else if (r < 35)
            return 16'h7FFF;
        else if (r < 38)
            return 16'hFFFF;
        return 16'($urandom_range(16'hFFFF));
    endfunction

    // one random word; some loads aim past the last oscillator
    task automatic random_word();
        int          r;
        logic [11:0] slot;
        r = $urandom_range(99);
        if ($urandom_range(9) == 0)
            slot = 12'($urandom_range(4095, NOSC));
        else
            slot = 12'($urandom_range(NOSC - 1));
        if (r < 28)
            play_tick($urandom_range(99) < 85);
        else if (r < 45)
            send_word(OP_STEP, slot, pick_step(), 1'($urandom_range(1)));
        else if (r < 72)
            send_word(OP_AMP, slot, {16'($urandom_range(16'hFFFF)), pick_gain()},
                      1'($urandom_range(1)));
        else
            send_word(OP_WAVE, 12'($urandom_range(4095)), $urandom,
                      1'($urandom_range(1)));
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int tx_pct [4];
        int rx_pct [4];
        int phase_stop;

        tx_pct = '{0, 45, 0, 19};
        rx_pct = '{0, 0, 45, 19};
        sb = new();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // tick straight out of reset, before any note
        send_word(OP_TICK, 12'hFFF, 32'hFFFF_FFFF, 1'b0);

        // load every step so that ticks with notes are defined
        for (int k = 0; k < NOSC; k++)
        begin
            if (k == 0)
                send_word(OP_STEP, 12'(k), 32'h0000_0000, 1'b0);
            else if (k == 1)
                send_word(OP_STEP, 12'(k), 32'hFFFF_FFFF, 1'b1);
            else
                send_word(OP_STEP, 12'(k), pick_step(), 1'($urandom_range(1)));
        end

        // notes held but every gain still zero: mid-level
        send_word(OP_TICK, 12'h000, 32'h0000_0000, 1'b1);

        // loads aimed past the last oscillator must leave no trace
        send_word(OP_STEP, 12'(NOSC), 32'hFFFF_FFFF, 1'b1);
        send_word(OP_STEP, 12'hFFF, 32'h1234_5678, 1'b0);
        send_word(OP_AMP, 12'(NOSC), 32'h0000_7FFF, 1'b0);
        send_word(OP_AMP, 12'hFFF, 32'hFFFF_FFFF, 1'b1);

        // gains at both signed extremes, upper value bits set and ignored
        send_word(OP_AMP, 12'd0, 32'hFFFF_7FFF, 1'b0);
        send_word(OP_AMP, 12'(NOSC - 1), 32'h0000_8000, 1'b1);
        send_word(OP_AMP, 12'd1, 32'hABCD_0001, 1'b0);
        send_word(OP_WAVE, 12'h000, 32'hFFFF_7FFF, 1'b1);
        send_word(OP_WAVE, 12'hFFF, 32'h0000_8000, 1'b0);

        play_tick(1'b1);
        play_tick(1'b0);
        play_tick(1'b1);

        // saturating products make the sum wrap in both directions
        flood_tick(16'h8000, 16'h8000);
        flood_tick(16'h7FFF, 16'h7FFF);
        flood_tick(16'h8000, 16'h7FFF);
        play_tick(1'b0);
        play_tick(1'b1);

        // random phases with changing idle patterns on both sides
        for (int ph = 0; ph < 4; ph++)
        begin
            tx_idle_pct  = tx_pct[ph];
            rx_stall_pct = rx_pct[ph];
            if (ph == 0 || ph == 3)
            begin
                // hold the receiver off; the first sample waits, the second
                // tick ties up the input while words keep coming
                rx_hold_len = 300;
                rx_hold_id++;
                play_tick(1'b0);
                play_tick(1'b0);
            end
            phase_stop = words_taken + RANDOM_WORDS;
            while (words_taken < phase_stop)
                random_word();
            drain_samples();
        end

        // wait out any late output from the bank
        repeat (SETTLE_TIME) @(posedge clk);

        $display("Run covered %0d words taken (%0d wave loads ahead of ticks), %0d samples",
                 words_taken, fill_words, sb.samples_checked);
        $display("of which %0d with notes held; %0d mismatches", sb.active_ticks,
                 sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
